// ===== sv/lj_pkg.sv =====
// Shared types and constants for the Lennard-Jones pair force pipeline.
package lj_pkg;

    // Default number of fraction bits of every fixed-point value.
    localparam int LJ_FRAC_BITS = 16;

    // Multiplier results and the force quotient are clamped to this value.
    localparam logic [63:0] LJ_CAP = 64'h4000_0000_0000_0000;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_SIGMA_SQUARED = 1'b0,
        CFG_WELL_DEPTH    = 1'b1
    } lj_cfg_t;

    // Per-pair geometry carried alongside the arithmetic.
    typedef struct packed {
        logic            zero;
        logic [2:0]      dneg;
        logic [2:0][31:0] mag;
    } lj_geom_t;

endpackage

// ===== sv/lj_dist.sv =====
// Front end: coordinate differences, squares and the truncated squared distance.
module lj_dist #(
    parameter int FRAC_BITS = lj_pkg::LJ_FRAC_BITS,
    parameter int R2W       = 66 - FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2:0][31:0]      pos_a,
    input  logic [2:0][31:0]      pos_b,
    output logic                  out_valid,
    output logic [R2W-1:0]        r2,
    output lj_pkg::lj_geom_t      geom
);
    import lj_pkg::*;

    logic             v1_reg, v2_reg, v3_reg;
    logic [2:0]       dneg1_reg, dneg2_reg;
    logic [2:0][31:0] mag1_reg, mag2_reg;
    logic [2:0][63:0] sq_reg;
    logic [2:0][31:0] mag_next;
    logic [2:0]       dneg_next;
    logic [65:0]      sum;
    logic [R2W-1:0]   r2_raw;
    logic [R2W-1:0]   r2_reg;
    lj_geom_t         geom_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [32:0] diff;
            diff         = {pos_b[i][31], pos_b[i]} - {pos_a[i][31], pos_a[i]};
            dneg_next[i] = diff[32];
            mag_next[i]  = diff[32] ? 32'(-diff) : diff[31:0];
        end
    end

    assign sum    = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
    assign r2_raw = sum[65:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dneg1_reg <= dneg_next;
            mag1_reg  <= mag_next;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= 64'(mag1_reg[i]) * 64'(mag1_reg[i]);
            end
            dneg2_reg <= dneg1_reg;
            mag2_reg  <= mag1_reg;
            // Coincident particles still get a nonzero divisor downstream.
            r2_reg        <= (r2_raw == '0) ? R2W'(1) : r2_raw;
            geom_reg.zero <= (mag2_reg[0] == '0) && (mag2_reg[1] == '0)
                             && (mag2_reg[2] == '0);
            geom_reg.dneg <= dneg2_reg;
            geom_reg.mag  <= mag2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign r2        = r2_reg;
    assign geom      = geom_reg;

endmodule

// ===== sv/lj_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module lj_div #(
    parameter int NW = 48,
    parameter int DW = 50,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          valid_reg [NW];
    logic [NW-1:0] quo_reg   [NW];
    logic [SW-1:0] side_reg  [NW];
    logic [NW-1:0] num_reg   [NW-1];
    logic [DW-1:0] den_reg   [NW-1];
    logic [DW-1:0] rem_reg   [NW-1];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          v_in;
        logic [NW-1:0] num_in;
        logic [NW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [DW-1:0] rem_in;
        logic [SW-1:0] side_k;
        logic [DW:0]   shifted;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign num_in = num;
            assign quo_in = '0;
            assign den_in = den;
            assign rem_in = '0;
            assign side_k = side_in;
        end else begin : g_next
            assign v_in   = valid_reg[k-1];
            assign num_in = num_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign side_k = side_reg[k-1];
        end

        // The partial remainder stays below the divisor, so the sign of the
        // trial subtraction decides the quotient bit.
        assign shifted  = {rem_in, num_in[NW-1-k]};
        assign diff     = shifted - {1'b0, den_in};
        assign ge       = !diff[DW];
        assign rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];

        always_comb begin
            quo_next         = quo_in;
            quo_next[NW-1-k] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_k;
            end
        end

        if (k < NW - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en) begin
                    num_reg[k] <= num_in;
                    den_reg[k] <= den_in;
                    rem_reg[k] <= rem_next;
                end
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign quo       = quo_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

// ===== sv/lj_mulsh.sv =====
// Four-stage 64x64 multiply, shift down by the fraction bits and clamp.
module lj_mulsh #(
    parameter int FRAC_BITS = lj_pkg::LJ_FRAC_BITS,
    parameter int SW        = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [63:0]   a,
    input  logic [63:0]   b,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [63:0]   res,
    output logic          huge,
    output logic [SW-1:0] side_out
);
    import lj_pkg::*;

    localparam int RW = 128 - FRAC_BITS;

    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [SW-1:0] s1_reg, s2_reg, s3_reg, s4_reg;
    logic [63:0]   ll_reg, lh_reg, hl_reg, hh_reg;
    logic [63:0]   ll2_reg, hh2_reg;
    logic [64:0]   mid_reg;
    logic [127:0]  prod_reg;
    logic [RW-1:0] shifted;
    logic          over;
    logic [63:0]   res_reg;
    logic          huge_reg;

    assign shifted = prod_reg[127:FRAC_BITS];
    assign over    = shifted > RW'(LJ_CAP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg   <= 64'(a[31:0])  * 64'(b[31:0]);
            lh_reg   <= 64'(a[31:0])  * 64'(b[63:32]);
            hl_reg   <= 64'(a[63:32]) * 64'(b[31:0]);
            hh_reg   <= 64'(a[63:32]) * 64'(b[63:32]);
            s1_reg   <= side_in;
            mid_reg  <= {1'b0, lh_reg} + {1'b0, hl_reg};
            ll2_reg  <= ll_reg;
            hh2_reg  <= hh_reg;
            s2_reg   <= s1_reg;
            prod_reg <= {hh2_reg, ll2_reg} + {31'b0, mid_reg, 32'b0};
            s3_reg   <= s2_reg;
            res_reg  <= over ? LJ_CAP : shifted[63:0];
            huge_reg <= over;
            s4_reg   <= s3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign res       = res_reg;
    assign huge      = huge_reg;
    assign side_out  = s4_reg;

endmodule

// ===== sv/lennard_jones_pair_force.sv =====
// Top level of the Lennard-Jones 12-6 pair force pipeline.
//
// This block takes one particle pair per item and returns the Lennard-Jones
// force delta on particle A, f*(pos_b - pos_a) per axis, in signed fixed point
// with FRAC_BITS fraction bits; software adds it to A and subtracts it from B.
// It accepts one item every clock cycle while the result side is not stalled.
// Most of the pipeline depth lies in the two restoring dividers, which
// produce one quotient bit per pipeline stage: sigma^2/r2 takes 32 + FRAC_BITS
// stages and the force scaling by 1/r2 takes 63 + FRAC_BITS stages. The whole
// pipeline advances together and holds while the output item waits, so a stall
// on the result side loses and repeats nothing. Coincident particles give zero
// force and raise zero_distance; any force component clamped to the 32-bit
// range raises saturated. Write sigma_squared and well_depth only while no
// item is in flight; they are read live by the pipeline.
module lennard_jones_pair_force #(
    parameter int FRAC_BITS = lj_pkg::LJ_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, 32 bits each.
    input  logic [191:0]          s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // force_x, force_y, force_z, 32 bits each.
    output logic [95:0]           m_tdata,
    // zero_distance, saturated.
    output logic [1:0]            m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_wr_en,
    input  lj_pkg::lj_cfg_t       cfg_addr,
    input  logic [31:0]           cfg_wdata
);
    import lj_pkg::*;

    localparam int R2W = 66 - FRAC_BITS;
    localparam int QW  = 32 + FRAC_BITS;
    localparam int NW2 = 63 + FRAC_BITS;
    localparam int GW  = $bits(lj_geom_t);

    // The whole pipeline moves whenever the output register is free.
    logic en;

    logic [31:0] sigma_reg;
    logic [31:0] well_reg;

    // Configuration writes land directly in the registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg <= 32'(64'(1) << FRAC_BITS);
            well_reg  <= 32'(64'(5) << FRAC_BITS);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SIGMA_SQUARED: sigma_reg <= cfg_wdata;
                CFG_WELL_DEPTH:    well_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Distance front end.
    logic [2:0][31:0] pos_a, pos_b;
    logic             v_dist;
    logic [R2W-1:0]   r2_dist;
    lj_geom_t         geom_dist;

    assign pos_a = s_tdata[95:0];
    assign pos_b = s_tdata[191:96];

    lj_dist #(.FRAC_BITS(FRAC_BITS), .R2W(R2W)) u_dist (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid),
        .pos_a(pos_a), .pos_b(pos_b),
        .out_valid(v_dist), .r2(r2_dist), .geom(geom_dist)
    );

    // q = sigma^2 / r2 in fixed point.
    logic           v_d1;
    logic [QW-1:0]  q_d1;
    logic [R2W-1:0] r2_d1;
    lj_geom_t       geom_d1;

    lj_div #(.NW(QW), .DW(R2W), .SW(R2W + GW)) u_div_q (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_dist),
        .num({sigma_reg, {FRAC_BITS{1'b0}}}), .den(r2_dist),
        .side_in({r2_dist, geom_dist}),
        .out_valid(v_d1), .quo(q_d1), .side_out({r2_d1, geom_d1})
    );

    // s = q^3, formed as (q*q)*q.
    logic           v_m1, huge_m1;
    logic [63:0]    qq_m1;
    logic [QW-1:0]  q_m1;
    logic [R2W-1:0] r2_m1;
    lj_geom_t       geom_m1;

    lj_mulsh #(.FRAC_BITS(FRAC_BITS), .SW(QW + R2W + GW)) u_mul_qq (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_d1),
        .a(64'(q_d1)), .b(64'(q_d1)), .side_in({q_d1, r2_d1, geom_d1}),
        .out_valid(v_m1), .res(qq_m1), .huge(huge_m1),
        .side_out({q_m1, r2_m1, geom_m1})
    );

    logic           v_m2, huge_m2, h_m2;
    logic [63:0]    s_m2;
    logic [R2W-1:0] r2_m2;
    lj_geom_t       geom_m2;

    lj_mulsh #(.FRAC_BITS(FRAC_BITS), .SW(1 + R2W + GW)) u_mul_s (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m1),
        .a(qq_m1), .b(64'(q_m1)), .side_in({huge_m1, r2_m1, geom_m1}),
        .out_valid(v_m2), .res(s_m2), .huge(huge_m2),
        .side_out({h_m2, r2_m2, geom_m2})
    );

    // g = 1 - 2s as sign and magnitude, and k = 24 * epsilon.
    logic [63:0] one_fx, t_m2, gmag_m2, k_val;
    logic        gneg_m2;

    assign one_fx  = 64'(1) << FRAC_BITS;
    assign t_m2    = {s_m2[62:0], 1'b0};
    assign gneg_m2 = t_m2 > one_fx;
    assign gmag_m2 = gneg_m2 ? (t_m2 - one_fx) : (one_fx - t_m2);
    assign k_val   = (64'(well_reg) << 4) + (64'(well_reg) << 3);

    logic           v_m3, huge_m3, h_m3, gneg_m3;
    logic [63:0]    a_m3, gmag_m3;
    logic [R2W-1:0] r2_m3;
    lj_geom_t       geom_m3;

    lj_mulsh #(.FRAC_BITS(FRAC_BITS), .SW(2 + 64 + R2W + GW)) u_mul_a (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m2),
        .a(k_val), .b(s_m2),
        .side_in({h_m2 | huge_m2, gneg_m2, gmag_m2, r2_m2, geom_m2}),
        .out_valid(v_m3), .res(a_m3), .huge(huge_m3),
        .side_out({h_m3, gneg_m3, gmag_m3, r2_m3, geom_m3})
    );

    // b = a / r2 in fixed point; a never exceeds 2^62.
    logic           v_d2, h_d2, gneg_d2;
    logic [NW2-1:0] quo_d2;
    logic [63:0]    gmag_d2;
    lj_geom_t       geom_d2;

    lj_div #(.NW(NW2), .DW(R2W), .SW(2 + 64 + GW)) u_div_b (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m3),
        .num({a_m3[62:0], {FRAC_BITS{1'b0}}}), .den(r2_m3),
        .side_in({h_m3 | huge_m3, gneg_m3, gmag_m3, geom_m3}),
        .out_valid(v_d2), .quo(quo_d2),
        .side_out({h_d2, gneg_d2, gmag_d2, geom_d2})
    );

    // The integer part of the quotient is limited like the multiplier results.
    logic [62:0] qi_d2;
    logic        b_over;
    logic [63:0] b_val;

    assign qi_d2  = quo_d2[NW2-1:FRAC_BITS];
    assign b_over = qi_d2 > (63'(1) << (62 - FRAC_BITS));
    assign b_val  = b_over ? LJ_CAP : quo_d2[63:0];

    // fmag = b * |g|.
    logic        v_m4, huge_m4, h_m4, gneg_m4;
    logic [63:0] fmag_m4;
    lj_geom_t    geom_m4;

    lj_mulsh #(.FRAC_BITS(FRAC_BITS), .SW(2 + GW)) u_mul_f (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_d2),
        .a(b_val), .b(gmag_d2), .side_in({h_d2 | b_over, gneg_d2, geom_d2}),
        .out_valid(v_m4), .res(fmag_m4), .huge(huge_m4),
        .side_out({h_m4, gneg_m4, geom_m4})
    );

    logic h_all, fnz;

    assign h_all = h_m4 | huge_m4;
    assign fnz   = fmag_m4 != '0;

    // One multiplier per axis scales fmag by that axis' distance.
    logic [2:0]       v_ax, huge_ax, hx, gx, zx, fx, mnz, dn;
    logic [2:0][63:0] mag_ax;

    for (genvar i = 0; i < 3; i++) begin : g_axis
        lj_mulsh #(.FRAC_BITS(FRAC_BITS), .SW(6)) u_mul_axis (
            .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v_m4),
            .a(fmag_m4), .b(64'(geom_m4.mag[i])),
            .side_in({h_all, gneg_m4, geom_m4.zero, fnz,
                      geom_m4.mag[i] != '0, geom_m4.dneg[i]}),
            .out_valid(v_ax[i]), .res(mag_ax[i]), .huge(huge_ax[i]),
            .side_out({hx[i], gx[i], zx[i], fx[i], mnz[i], dn[i]})
        );
    end

    // Output stage: force an over-range pair to full scale, then clamp to the
    // 32-bit signed range, rounding stays toward zero throughout.
    logic [2:0][31:0] force_next;
    logic [2:0]       sat_ax;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic        forced;
            logic        big;
            logic [63:0] mag;
            forced = hx[0] && fx[0] && mnz[i];
            mag    = forced ? LJ_CAP : mag_ax[i];
            big    = forced || huge_ax[i];
            if (gx[0] ^ dn[i]) begin
                sat_ax[i]     = big || (mag > 64'h8000_0000);
                force_next[i] = sat_ax[i] ? 32'h8000_0000 : 32'(-mag);
            end else begin
                sat_ax[i]     = big || (mag > 64'h7FFF_FFFF);
                force_next[i] = sat_ax[i] ? 32'h7FFF_FFFF : mag[31:0];
            end
        end
    end

    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= &v_ax;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (zx[0]) begin
                // Coincident particles: no force and no clamp report.
                m_tdata_reg <= '0;
                m_tuser_reg <= 2'b01;
            end else begin
                m_tdata_reg <= force_next;
                m_tuser_reg <= {|sat_ax, 1'b0};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
